// ===== rtl/cfpr_pkg.sv =====
// cfpr_pkg: shared types and constants for the circular fifo with prefix reverse
// no dependencies; compiled first

package cfpr_pkg;

	localparam int DATA_W  = 32;
	localparam int COUNT_W = 5;
	localparam int LEVEL_W = 5;

	// operation codes carried by an input transfer
	typedef enum logic [1:0] {
		KIND_PUSH = 2'd0,
		KIND_POP  = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_REV  = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// reverse sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_REV_RD = 2'd1,
		ST_REV_WA = 2'd2,
		ST_REV_WB = 2'd3
	} state_t;

endpackage

// ===== rtl/cfpr_in_if.sv =====
// cfpr_in_if: valid/ready channel carrying one fifo operation
// depends on cfpr_pkg

interface cfpr_in_if;
	logic                               valid;
	logic                               ready;
	cfpr_pkg::kind_t                    kind;
	logic signed [cfpr_pkg::DATA_W-1:0] data_in;
	logic [cfpr_pkg::COUNT_W-1:0]       count;

	modport source(output valid, kind, data_in, count, input ready);
	modport sink(input valid, kind, data_in, count, output ready);
endinterface

// ===== rtl/cfpr_out_if.sv =====
// cfpr_out_if: valid/ready channel carrying one fifo result
// depends on cfpr_pkg

interface cfpr_out_if;
	logic                               valid;
	logic                               ready;
	cfpr_pkg::status_t                  status;
	logic signed [cfpr_pkg::DATA_W-1:0] data_out;
	logic [cfpr_pkg::LEVEL_W-1:0]       level;

	modport source(output valid, status, data_out, level, input ready);
	modport sink(input valid, status, data_out, level, output ready);
endinterface

// ===== rtl/cfpr_ram.sv =====
// cfpr_ram: generic synchronous ram, one write port and two registered read ports
// no dependencies

module cfpr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== rtl/circular_fifo_with_prefix_reverse.sv =====
// circular_fifo_with_prefix_reverse: ring-buffer fifo with in-place head reversal
// depends on cfpr_pkg, cfpr_in_if, cfpr_out_if, cfpr_ram
//
//  channel   dir  transfer when        payload
//  items     in   valid & ready        kind, data_in, count
//  results   out  valid & ready        status, data_out, level
//
// push, pop and peek act at their transfer; a result passes the result stage and
// then the output register, and a new operation follows once the stage is free
// or moving out. reverse swaps floor(k / 2) pairs, k being the clamped count: each
// swap reads both entries, then writes them back over the single write port.
// reset (arst_n low) empties the fifo; stored words are not cleared.
// a stalled result is held in the output register plus one stage behind it.

module circular_fifo_with_prefix_reverse #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	cfpr_in_if.sink    items,
	cfpr_out_if.source results
);
	import cfpr_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int OW   = $clog2(DEPTH + 1);
	localparam int CMPW = (OW > COUNT_W) ? OW : COUNT_W;
	localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
	localparam logic [OW-1:0] DEPTH_O = OW'(DEPTH);

	// pointer plus offset, modulo depth
	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_A) begin
			sum = sum - DEPTH_A;
		end
		return sum[AW-1:0];
	endfunction

	state_t          state_q, state_d;
	logic [AW-1:0]   head_q, head_d, tail_q, tail_d;
	logic [OW-1:0]   occ_q, occ_d, k_q, k_d, pair_q, pair_d;

	logic            s1_valid_s1, s1_rd_s1;
	status_t         s1_status_s1;
	logic [LEVEL_W-1:0] s1_level_s1;
	logic            s1_load, s1_rd_d;
	status_t         s1_status_d;

	logic            out_valid_q;
	status_t         out_status_q;
	logic signed [DATA_W-1:0] out_data_q;
	logic [LEVEL_W-1:0] out_level_q;

	logic            out_load, in_ready, accept;
	logic [OW-1:0]   k_clamp, off_b, half;
	logic [AW-1:0]   addr_a, addr_b;
	logic            last_pair;

	logic            ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr_a, ram_raddr_b;
	logic [DATA_W-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;

	cfpr_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr_a(ram_raddr_a),
		.raddr_b(ram_raddr_b),
		.rdata_a(ram_rdata_a),
		.rdata_b(ram_rdata_b)
	);

	// handshake: the stage behind the output register frees the input side
	assign out_load = s1_valid_s1 && (!out_valid_q || results.ready);
	assign in_ready = (state_q == ST_IDLE) && (!s1_valid_s1 || out_load);
	assign accept   = items.valid && in_ready;
	assign items.ready = in_ready;

	// clamp the reverse length to the occupancy
	assign k_clamp = OW'((CMPW'(items.count) > CMPW'(occ_q)) ? CMPW'(occ_q)
		: CMPW'(items.count));

	// swap pair addresses
	assign half      = k_q >> 1;
	assign off_b     = k_q - OW'(1) - pair_q;
	assign addr_a    = wrap_add(head_q, AW'(pair_q));
	assign addr_b    = wrap_add(head_q, AW'(off_b));
	assign last_pair = (pair_q == half - OW'(1));

	// next state, ram control and result capture
	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		occ_d       = occ_q;
		k_d         = k_q;
		pair_d      = pair_q;
		ram_we      = 1'b0;
		ram_waddr   = tail_q;
		ram_wdata   = items.data_in;
		ram_re      = 1'b0;
		ram_raddr_a = head_q;
		ram_raddr_b = addr_b;
		s1_load     = 1'b0;
		s1_status_d = STATUS_OK;
		s1_rd_d     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (items.kind)
						KIND_PUSH: begin
							s1_load = 1'b1;
							if (occ_q == DEPTH_O) begin
								s1_status_d = STATUS_FULL;
							end else begin
								ram_we = 1'b1;
								tail_d = wrap_add(tail_q, AW'(1));
								occ_d  = occ_q + OW'(1);
							end
						end
						KIND_POP, KIND_PEEK: begin
							s1_load = 1'b1;
							if (occ_q == '0) begin
								s1_status_d = STATUS_EMPTY;
							end else begin
								ram_re  = 1'b1;
								s1_rd_d = 1'b1;
								if (items.kind == KIND_POP) begin
									head_d = wrap_add(head_q, AW'(1));
									occ_d  = occ_q - OW'(1);
								end
							end
						end
						KIND_REV: begin
							if (k_clamp < OW'(2)) begin
								s1_load = 1'b1;
							end else begin
								k_d     = k_clamp;
								pair_d  = '0;
								state_d = ST_REV_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_REV_RD: begin
				ram_re      = 1'b1;
				ram_raddr_a = addr_a;
				ram_raddr_b = addr_b;
				state_d     = ST_REV_WA;
			end
			ST_REV_WA: begin
				ram_we    = 1'b1;
				ram_waddr = addr_a;
				ram_wdata = ram_rdata_b;
				state_d   = ST_REV_WB;
			end
			ST_REV_WB: begin
				ram_we    = 1'b1;
				ram_waddr = addr_b;
				ram_wdata = ram_rdata_a;
				if (last_pair) begin
					s1_load = 1'b1;
					state_d = ST_IDLE;
				end else begin
					pair_d  = pair_q + OW'(1);
					state_d = ST_REV_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			k_q     <= '0;
			pair_q  <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			k_q     <= k_d;
			pair_q  <= pair_d;
		end
	end

	// result stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_load) begin
				s1_valid_s1 <= 1'b1;
			end else if (out_load) begin
				s1_valid_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; read data joins when the stage moves to the output
	always_ff @(posedge clk) begin
		if (s1_load) begin
			s1_status_s1 <= s1_status_d;
			s1_rd_s1     <= s1_rd_d;
			s1_level_s1  <= LEVEL_W'(occ_d);
		end
		if (out_load) begin
			out_status_q <= s1_status_s1;
			out_data_q   <= s1_rd_s1 ? ram_rdata_a : '0;
			out_level_q  <= s1_level_s1;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.status   = out_status_q;
	assign results.data_out = out_data_q;
	assign results.level    = out_level_q;

`ifndef SYNTHESIS
	// occupancy stays within the ring
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= DEPTH_O)
		else $error("occupancy above depth");

	// empty or full ring has head and tail on the same slot
	a_ptr_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0 || occ_q == DEPTH_O) |-> (head_q == tail_q))
		else $error("head and tail disagree with occupancy");

	// no transfer is taken while a reversal is in flight
	a_rev_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !items.ready)
		else $error("input ready during reversal");

	// a result waiting behind a stalled output is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !out_load) |=> s1_valid_s1)
		else $error("pending result lost");
`endif

endmodule
